// ===== sv/audio_peak_envelope_builder_defines.svh =====
// Assertion macros shared by the peak envelope builder RTL.
`ifndef AUDIO_PEAK_ENVELOPE_BUILDER_DEFINES_SVH
`define AUDIO_PEAK_ENVELOPE_BUILDER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge of clk outside reset.
`define APEB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge of clk outside reset.
`define APEB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/apeb_pkg.sv =====
// Types and constants of the audio peak envelope builder.
`timescale 1ns / 1ps
package apeb_pkg;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_SOURCE_RATE = 1'b0,
    CFG_PEAK_GAIN   = 1'b1
  } cfg_idx_t;

  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned RATE_W     = 18;
  localparam int unsigned GAIN_W     = 15;
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned PEAK_W     = 16;

  localparam logic [RATE_W-1:0] SOURCE_RATE_RST = 18'd44100;
  localparam logic [GAIN_W-1:0] PEAK_GAIN_RST   = 15'd32767;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;

  localparam logic signed [PEAK_W-1:0] PEAK_POS_SAT = 16'sh7FFF;
  localparam logic signed [PEAK_W-1:0] PEAK_NEG_SAT = 16'sh8000;

  // Largest magnitude a Q1.23 sample can have (full-scale negative).
  localparam logic [SAMPLE_W-1:0] MAG_MAX = 24'h800000;

endpackage

// ===== sv/apeb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module apeb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/audio_peak_envelope_builder.sv =====
// Top level of the audio peak envelope builder (min/max peak decimation).
`timescale 1ns / 1ps
`include "audio_peak_envelope_builder_defines.svh"

// The block takes one word per clock while in_stall is low and returns a
// result word, through its stage registers and the output register, when the
// word closes a peak window, a norm chunk, or is a flush of a partly filled
// window; other words give no result. Per-channel state lives in one
// synchronous RAM, one entry per channel, that is read in the cycle a word is
// accepted and written back as the word leaves stage 1; a bypass register
// covers back-to-back words of the same channel, so that single
// read-modify-write loop sets the rate of one word per cycle. Entries carry
// valid bits, so the block is ready right after reset with no clearing pass.
// Two multipliers scale the peak pair by the gain in a stage of their own. The
// input stalls only when a result waits at the output and the stage behind it
// is also full. A configuration write can reach words accepted before it.
module audio_peak_envelope_builder #(
  parameter int unsigned CHANNELS        = 2,
  parameter int unsigned FRAMES_PER_PEAK = 64,
  parameter int unsigned NORM_CHUNK      = 10000,
  parameter int unsigned REFERENCE_RATE  = 44100
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_wr_en,
  input  apeb_pkg::cfg_idx_t            cfg_index,
  input  logic [apeb_pkg::CFG_DATA_W-1:0] cfg_wdata,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [3:0]                    in_channel,
  input  logic signed [apeb_pkg::SAMPLE_W-1:0] in_sample,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    out_channel,
  output logic                          out_peak_valid,
  output logic signed [apeb_pkg::PEAK_W-1:0] out_upper_peak,
  output logic signed [apeb_pkg::PEAK_W-1:0] out_lower_peak,
  output logic                          out_norm_valid,
  output logic [apeb_pkg::SAMPLE_W-1:0] out_norm_value
);

  import apeb_pkg::*;

  localparam int unsigned AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned LEN_W = $clog2(FRAMES_PER_PEAK) + RATE_W;
  localparam int unsigned PH_W  = LEN_W + 2;
  localparam int unsigned CNT_W = $clog2(NORM_CHUNK + 1);
  localparam int unsigned PHI_W = SAMPLE_W + GAIN_W + 1;
  localparam int unsigned PLO_W = PHI_W + 1;
  localparam int unsigned SHIFT = SAMPLE_W - 1;

  localparam logic signed [PH_W-1:0] REF_PH    = PH_W'(REFERENCE_RATE);
  localparam logic [CNT_W-1:0]       CNT_LAST  = CNT_W'(NORM_CHUNK);
  localparam logic [4:0]             CHAN_LIM  = 5'(CHANNELS);
  localparam logic [LEN_W-1:0]       LEN_RST   = LEN_W'(FRAMES_PER_PEAK) *
                                                 LEN_W'(SOURCE_RATE_RST);

  typedef struct packed {
    logic signed [PH_W-1:0]     phase;
    logic signed [SAMPLE_W-1:0] wmax;
    logic signed [SAMPLE_W-1:0] wmin;
    logic [SAMPLE_W-1:0]        mag;
    logic [CNT_W-1:0]           count;
  } chan_state_t;

  localparam chan_state_t STATE_RST = '{
    phase: '0, wmax: SAMPLE_MIN, wmin: SAMPLE_MAX, mag: '0, count: '0
  };

  // Saturates a truncated product to the 16-bit peak range.
  function automatic logic signed [PEAK_W-1:0] sat_peak(
    input logic signed [PLO_W-SHIFT-1:0] q
  );
    logic signed [PEAK_W-1:0] r;
    if (q > (PLO_W-SHIFT)'(PEAK_POS_SAT)) begin
      r = PEAK_POS_SAT;
    end else if (q < (PLO_W-SHIFT)'(PEAK_NEG_SAT)) begin
      r = PEAK_NEG_SAT;
    end else begin
      r = q[PEAK_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers and derived window length.
  logic [RATE_W-1:0]        source_rate_r;
  logic [GAIN_W-1:0]        peak_gain_r;
  logic [LEN_W-1:0]         len_r;
  logic [LEN_W-1:0]         len_nxt;
  logic signed [PH_W-1:0]   len_m_ref_r;

  assign len_nxt = LEN_W'(source_rate_r) * LEN_W'(FRAMES_PER_PEAK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_rate_r <= SOURCE_RATE_RST;
      peak_gain_r   <= PEAK_GAIN_RST;
      len_r         <= LEN_RST;
      len_m_ref_r   <= $signed(PH_W'(LEN_RST)) - REF_PH;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SOURCE_RATE: source_rate_r <= cfg_wdata[RATE_W-1:0];
          CFG_PEAK_GAIN:   peak_gain_r   <= cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      len_r       <= len_nxt;
      len_m_ref_r <= $signed(PH_W'(len_nxt)) - REF_PH;
    end
  end

  // Pipeline control.
  logic adv;
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_valid_r;

  assign adv      = !(out_valid_r && out_stall && s3_vld_r);
  assign in_stall = !adv;

  // Stage 1: state read from RAM, updated and written back.
  logic                       s1_func_r;
  logic [3:0]                 s1_ch_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic [CHANNELS-1:0]        ent_vld_r;
  logic                       wb_vld_r;
  logic [AW-1:0]              wb_addr_r;
  chan_state_t                wb_state_r;
  logic [$bits(chan_state_t)-1:0] ram_rd_data;
  chan_state_t                cur;
  chan_state_t                upd;
  logic [AW-1:0]              s1_addr;
  logic                       ram_we;

  assign s1_addr = s1_ch_r[AW-1:0];
  assign ram_we  = s1_vld_r && adv;

  apeb_ram #(
    .WIDTH ($bits(chan_state_t)),
    .DEPTH (CHANNELS),
    .ADDR_W(AW)
  ) u_state_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(s1_addr),
    .wr_data(upd),
    .rd_en  (adv),
    .rd_addr(in_channel[AW-1:0]),
    .rd_data(ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      ent_vld_r <= '0;
      wb_vld_r  <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid && (5'(in_channel) < CHAN_LIM);
      wb_vld_r <= s1_vld_r;
      if (s1_vld_r) begin
        ent_vld_r[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func_r   <= in_func;
      s1_ch_r     <= in_channel;
      s1_sample_r <= in_sample;
      wb_addr_r   <= s1_addr;
      wb_state_r  <= upd;
    end
  end

  // The bypass register wins when the previous word wrote this channel in the
  // same edge that this word's read took place.
  always_comb begin
    if (wb_vld_r && (wb_addr_r == s1_addr)) begin
      cur = wb_state_r;
    end else if (ent_vld_r[s1_addr]) begin
      cur = chan_state_t'(ram_rd_data);
    end else begin
      cur = STATE_RST;
    end
  end

  logic signed [SAMPLE_W:0]   s_ext;
  logic [SAMPLE_W-1:0]        s_mag;
  logic [SAMPLE_W-1:0]        mag_new;
  logic signed [SAMPLE_W-1:0] max_new;
  logic signed [SAMPLE_W-1:0] min_new;
  logic signed [PH_W-1:0]     ph_dec;
  logic signed [PH_W-1:0]     ph_sum;
  logic signed [PH_W-1:0]     ph_chk;
  logic                       win_close;
  logic                       chunk_close;
  logic                       s2_vld_nxt;
  logic                       s2_peak_nxt;
  logic                       s2_norm_nxt;
  logic signed [SAMPLE_W-1:0] s2_max_nxt;
  logic signed [SAMPLE_W:0]   s2_nmin_nxt;

  assign s_ext   = (SAMPLE_W+1)'(s1_sample_r);
  assign s_mag   = s_ext[SAMPLE_W] ? SAMPLE_W'(-s_ext) : SAMPLE_W'(s_ext);
  assign mag_new = (s_mag > cur.mag) ? s_mag : cur.mag;
  assign max_new = (s1_sample_r > cur.wmax) ? s1_sample_r : cur.wmax;
  assign min_new = (s1_sample_r < cur.wmin) ? s1_sample_r : cur.wmin;

  // Three parallel adds: frame step, frame step plus window, and the clamp test
  // (phase plus window below zero means the result falls under -REFERENCE_RATE).
  assign ph_dec = cur.phase - REF_PH;
  assign ph_sum = cur.phase + len_m_ref_r;
  assign ph_chk = cur.phase + $signed(PH_W'(len_r));

  assign win_close   = ph_dec[PH_W-1] || (ph_dec == '0);
  assign chunk_close = (cur.count == CNT_LAST);

  always_comb begin
    upd         = STATE_RST;
    s2_peak_nxt = 1'b0;
    s2_norm_nxt = 1'b0;
    s2_max_nxt  = cur.wmax;
    s2_nmin_nxt = -(SAMPLE_W+1)'(cur.wmin);
    if (s1_func_r) begin
      // Flush: emit only a partly filled window, then return to reset state.
      s2_peak_nxt = !cur.phase[PH_W-1] && (cur.phase != '0);
    end else begin
      s2_max_nxt  = max_new;
      s2_nmin_nxt = -(SAMPLE_W+1)'(min_new);
      s2_peak_nxt = win_close;
      s2_norm_nxt = chunk_close;
      if (win_close) begin
        upd.wmax  = SAMPLE_MIN;
        upd.wmin  = SAMPLE_MAX;
        upd.phase = ph_chk[PH_W-1] ? -REF_PH : ph_sum;
      end else begin
        upd.wmax  = max_new;
        upd.wmin  = min_new;
        upd.phase = ph_dec;
      end
      upd.mag   = chunk_close ? '0 : mag_new;
      upd.count = (chunk_close ? '0 : cur.count) + CNT_W'(1);
    end
    s2_vld_nxt = s1_vld_r && (s2_peak_nxt || s2_norm_nxt);
  end

  // Stage 2: operands of the gain multiply.
  logic [3:0]                 s2_ch_r;
  logic                       s2_peak_r;
  logic                       s2_norm_r;
  logic signed [SAMPLE_W-1:0] s2_max_r;
  logic signed [SAMPLE_W:0]   s2_nmin_r;
  logic [SAMPLE_W-1:0]        s2_normv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ch_r    <= s1_ch_r;
      s2_peak_r  <= s2_peak_nxt;
      s2_norm_r  <= s2_norm_nxt;
      s2_max_r   <= s2_max_nxt;
      s2_nmin_r  <= s2_nmin_nxt;
      s2_normv_r <= mag_new;
    end
  end

  // Stage 3: products.
  logic signed [PHI_W-1:0] gain_hi;
  logic signed [PLO_W-1:0] gain_lo;
  logic signed [PHI_W-1:0] p_hi_nxt;
  logic signed [PLO_W-1:0] p_lo_nxt;
  logic [3:0]              s3_ch_r;
  logic                    s3_peak_r;
  logic                    s3_norm_r;
  logic signed [PHI_W-1:0] s3_p_hi_r;
  logic signed [PLO_W-1:0] s3_p_lo_r;
  logic [SAMPLE_W-1:0]     s3_normv_r;

  assign gain_hi  = $signed(PHI_W'(peak_gain_r));
  assign gain_lo  = $signed(PLO_W'(peak_gain_r));
  assign p_hi_nxt = PHI_W'(s2_max_r) * gain_hi;
  assign p_lo_nxt = PLO_W'(s2_nmin_r) * gain_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ch_r    <= s2_ch_r;
      s3_peak_r  <= s2_peak_r;
      s3_norm_r  <= s2_norm_r;
      s3_p_hi_r  <= p_hi_nxt;
      s3_p_lo_r  <= p_lo_nxt;
      s3_normv_r <= s2_normv_r;
    end
  end

  // Truncation toward zero: a negative product gets a bias of one LSB less than
  // the dropped weight before the arithmetic shift.
  logic signed [PHI_W-1:0]       sum_hi;
  logic signed [PLO_W-1:0]       sum_lo;
  logic signed [PLO_W-SHIFT-1:0] q_hi;
  logic signed [PLO_W-SHIFT-1:0] q_lo;
  logic signed [PEAK_W-1:0]      upper_nxt;
  logic signed [PEAK_W-1:0]      lower_nxt;

  assign sum_hi = s3_p_hi_r + $signed(PHI_W'({SHIFT{s3_p_hi_r[PHI_W-1]}}));
  assign sum_lo = s3_p_lo_r + $signed(PLO_W'({SHIFT{s3_p_lo_r[PLO_W-1]}}));
  assign q_hi   = (PLO_W-SHIFT)'($signed(sum_hi[PHI_W-1:SHIFT]));
  assign q_lo   = $signed(sum_lo[PLO_W-1:SHIFT]);

  assign upper_nxt = s3_peak_r ? sat_peak(q_hi) : '0;
  assign lower_nxt = s3_peak_r ? sat_peak(q_lo) : '0;

  // Output register.
  logic [3:0]               out_ch_r;
  logic                     out_peak_r;
  logic signed [PEAK_W-1:0] out_upper_r;
  logic signed [PEAK_W-1:0] out_lower_r;
  logic                     out_norm_r;
  logic [SAMPLE_W-1:0]      out_normv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= s3_vld_r && adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_ch_r    <= s3_ch_r;
      out_peak_r  <= s3_peak_r;
      out_upper_r <= upper_nxt;
      out_lower_r <= lower_nxt;
      out_norm_r  <= s3_norm_r;
      out_normv_r <= s3_norm_r ? s3_normv_r : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = out_ch_r;
  assign out_peak_valid = out_peak_r;
  assign out_upper_peak = out_upper_r;
  assign out_lower_peak = out_lower_r;
  assign out_norm_valid = out_norm_r;
  assign out_norm_value = out_normv_r;

  `APEB_ASSERT_NOW(a_no_empty_word, out_valid_r, out_peak_r || out_norm_r,
                   "result word carries nothing")
  `APEB_ASSERT_NOW(a_idle_peaks_zero, out_valid_r && !out_peak_r,
                   (out_upper_r == '0) && (out_lower_r == '0),
                   "peak fields set without a peak")
  `APEB_ASSERT_NOW(a_norm_range, out_valid_r && out_norm_r, out_normv_r <= MAG_MAX,
                   "norm value above full scale")
  `APEB_ASSERT_NEXT(a_s1_holds, s1_vld_r && !adv,
                    s1_vld_r && $stable(s1_ch_r) && $stable(s1_sample_r),
                    "stalled stage 1 word changed")
  `APEB_ASSERT_NEXT(a_bypass_loaded, ram_we, wb_vld_r && ent_vld_r[wb_addr_r],
                    "write-back not visible to bypass")

endmodule

// ===== tb/audio_peak_envelope_builder_tb.sv =====
// Self-checking testbench for the audio peak envelope builder.
`timescale 1ns / 1ps

module audio_peak_envelope_builder_tb;
  import apeb_pkg::*;

  localparam int NUM_CH = 2;
  localparam int FRAMES_PER_WINDOW = 64;
  localparam int CHUNK_LEN = 10000;
  localparam int REF_RATE = 44100;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_WORDS = 205;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef struct packed {
    logic [3:0] channel;
    logic peak_valid;
    logic signed [PEAK_W-1:0] upper;
    logic signed [PEAK_W-1:0] lower;
    logic norm_valid;
    logic [SAMPLE_W-1:0] norm;
  } envelope_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  cfg_idx_t cfg_index = CFG_SOURCE_RATE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = FUNC_SAMPLE;
  logic [3:0] in_channel = '0;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_channel;
  logic out_peak_valid;
  logic signed [PEAK_W-1:0] out_upper_peak;
  logic signed [PEAK_W-1:0] out_lower_peak;
  logic out_norm_valid;
  logic [SAMPLE_W-1:0] out_norm_value;

  // Predictor copy of the configuration and of the per-channel state.
  logic [RATE_W-1:0] model_rate;
  logic [GAIN_W-1:0] model_gain;
  longint win_phase[NUM_CH];
  int win_max[NUM_CH];
  int win_min[NUM_CH];
  int unsigned chunk_mag[NUM_CH];
  int unsigned chunk_cnt[NUM_CH];

  envelope_word_t pending_words[$];
  envelope_word_t predicted_word;
  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit sender_gaps = 1'b1;
  int stall_left = 0;
  int stall_pct = 0;

  audio_peak_envelope_builder #(
    .CHANNELS(NUM_CH),
    .FRAMES_PER_PEAK(FRAMES_PER_WINDOW),
    .NORM_CHUNK(CHUNK_LEN),
    .REFERENCE_RATE(REF_RATE)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_channel(in_channel),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_channel(out_channel),
    .out_peak_valid(out_peak_valid),
    .out_upper_peak(out_upper_peak),
    .out_lower_peak(out_lower_peak),
    .out_norm_valid(out_norm_valid),
    .out_norm_value(out_norm_value)
  );

  always #5 clk = ~clk;

  function automatic void clear_channel(int ch);
    win_phase[ch] = 0;
    win_max[ch] = SAMPLE_MIN;
    win_min[ch] = SAMPLE_MAX;
    chunk_mag[ch] = 0;
    chunk_cnt[ch] = 0;
  endfunction

  function automatic void reset_model();
    model_rate = SOURCE_RATE_RST;
    model_gain = PEAK_GAIN_RST;
    for (int c = 0; c < NUM_CH; c++) clear_channel(c);
  endfunction

  // Scales a Q1.23 value by the gain, truncates toward zero and saturates.
  function automatic logic [PEAK_W-1:0] scale_peak(longint v);
    longint prod;
    longint q;
    prod = v * longint'(model_gain);
    q = (prod < 0) ? -((-prod) >> 23) : (prod >> 23);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[PEAK_W-1:0];
  endfunction

  function automatic void fill_pair(int ch, inout envelope_word_t w);
    w.peak_valid = 1'b1;
    w.upper = scale_peak(longint'(win_max[ch]));
    w.lower = scale_peak(-longint'(win_min[ch]));
  endfunction

  function automatic bit predict_word(input logic func, input logic [3:0] ch,
                                      input logic signed [SAMPLE_W-1:0] smp,
                                      output envelope_word_t w);
    int s;
    int unsigned mag;
    bit made;
    w = '0;
    made = 1'b0;
    if (ch >= NUM_CH) return 1'b0;
    w.channel = ch;
    if (func == FUNC_FLUSH) begin
      if (win_phase[ch] > 0) begin
        fill_pair(ch, w);
        made = 1'b1;
      end
      clear_channel(ch);
      return made;
    end
    s = smp;
    mag = (s < 0) ? -s : s;
    if (mag > chunk_mag[ch]) chunk_mag[ch] = mag;
    if (s > win_max[ch]) win_max[ch] = s;
    if (s < win_min[ch]) win_min[ch] = s;
    win_phase[ch] -= REF_RATE;
    if (win_phase[ch] <= 0) begin
      fill_pair(ch, w);
      made = 1'b1;
      win_max[ch] = SAMPLE_MIN;
      win_min[ch] = SAMPLE_MAX;
      win_phase[ch] += longint'(FRAMES_PER_WINDOW) * longint'(model_rate);
      // A window shorter than one frame step would run away; it is held here.
      if (win_phase[ch] < -REF_RATE) win_phase[ch] = -REF_RATE;
    end
    if (chunk_cnt[ch] == CHUNK_LEN) begin
      w.norm_valid = 1'b1;
      w.norm = chunk_mag[ch][SAMPLE_W-1:0];
      made = 1'b1;
      chunk_mag[ch] = 0;
      chunk_cnt[ch] = 0;
    end
    chunk_cnt[ch] = (chunk_cnt[ch] + 1) & 32'h3FFF;
    return made;
  endfunction

  task automatic check_word();
    envelope_word_t got;
    envelope_word_t want;
    got.channel = out_channel;
    got.peak_valid = out_peak_valid;
    got.upper = out_upper_peak;
    got.lower = out_lower_peak;
    got.norm_valid = out_norm_valid;
    got.norm = out_norm_value;
    if (pending_words.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected word: ch %0d peak %b %0d %0d norm %b %0d", $time,
                 got.channel, got.peak_valid, got.upper, got.lower, got.norm_valid,
                 got.norm);
    end else begin
      want = pending_words.pop_front();
      if (got.channel !== want.channel || got.peak_valid !== want.peak_valid ||
          got.upper !== want.upper || got.lower !== want.lower ||
          got.norm_valid !== want.norm_valid || got.norm !== want.norm) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: expected %0d %b %0d %0d %b %0d, got %0d %b %0d %0d %b %0d",
                   $time, want.channel, want.peak_valid, want.upper, want.lower,
                   want.norm_valid, want.norm, got.channel, got.peak_valid,
                   got.upper, got.lower, got.norm_valid, got.norm);
      end
    end
  endtask

  // Tracks configuration writes and accepted words, and checks every result word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_SOURCE_RATE) model_rate = cfg_wdata[RATE_W-1:0];
        else model_gain = cfg_wdata[GAIN_W-1:0];
      end
      if (in_valid && !in_stall) begin
        if (predict_word(in_func, in_channel, in_sample, predicted_word))
          pending_words.push_back(predicted_word);
      end
      if (out_valid && !out_stall) check_word();
    end
  end

  // The receiver stalls in stretches, each with its own stall probability.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(10, 150);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 80;
      endcase
    end
    stall_left--;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("audio_peak_envelope_builder_tb failed");
    $finish;
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = SAMPLE_MAX;
      1: v = SAMPLE_MIN;
      2: v = int'($urandom_range(0, 510)) - 255;
      3, 4: v = int'($urandom_range(0, 131072)) - 65536;
      default: v = $urandom;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_word(input logic func, input logic [3:0] ch,
                           input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = sender_gaps ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_func <= func;
    in_channel <= ch;
    in_sample <= smp;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  // Holds the sender until every expected word is back and the pipeline is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [RATE_W-1:0] rate, input logic [GAIN_W-1:0] gain);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SOURCE_RATE;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_index <= CFG_PEAK_GAIN;
    cfg_wdata <= CFG_DATA_W'(gain);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // The first frame of a stream closes a window at once; full-scale and near-zero samples.
  task automatic test_first_frame();
    send_word(FUNC_SAMPLE, 4'd0, SAMPLE_MAX);
    send_word(FUNC_SAMPLE, 4'd0, SAMPLE_MIN);
    send_word(FUNC_SAMPLE, 4'd0, '0);
    send_word(FUNC_SAMPLE, 4'd0, -24'sd1);
    send_word(FUNC_SAMPLE, 4'd0, 24'sd1);
    send_word(FUNC_SAMPLE, 4'd1, SAMPLE_MIN);
  endtask

  task automatic test_flush();
    // Partly filled window, then the same channel again right after its flush.
    send_word(FUNC_FLUSH, 4'd0, rand_sample());
    send_word(FUNC_FLUSH, 4'd0, rand_sample());
    // Right after a window closed, the flush returns the cleared max and min.
    send_word(FUNC_SAMPLE, 4'd0, 24'sd5);
    send_word(FUNC_FLUSH, 4'd0, rand_sample());
    send_word(FUNC_FLUSH, 4'd1, rand_sample());
  endtask

  task automatic test_ignored_channels();
    send_word(FUNC_SAMPLE, 4'd2, SAMPLE_MAX);
    send_word(FUNC_FLUSH, 4'd15, SAMPLE_MIN);
    send_word(FUNC_SAMPLE, 4'd9, SAMPLE_MIN);
  endtask

  task automatic test_zero_rate_and_gain();
    set_config('0, '0);
    send_word(FUNC_SAMPLE, 4'd0, SAMPLE_MAX);
    send_word(FUNC_SAMPLE, 4'd0, SAMPLE_MIN);
    send_word(FUNC_SAMPLE, 4'd0, rand_sample());
    // A gain of three shows truncation toward zero rather than down.
    set_config('0, 15'd3);
    send_word(FUNC_SAMPLE, 4'd0, -24'sd8388607);
    send_word(FUNC_FLUSH, 4'd0, rand_sample());
  endtask

  task automatic test_short_window();
    set_config(18'd100, '1);
    repeat (4) send_word(FUNC_SAMPLE, 4'd1, rand_sample());
    send_word(FUNC_FLUSH, 4'd1, rand_sample());
  endtask

  task automatic test_random_settings();
    logic [RATE_W-1:0] rate;
    logic [GAIN_W-1:0] gain;
    logic [3:0] ch;
    int counted;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin rate = 18'd44100; gain = '1; end
        1: begin rate = '0; gain = '0; end
        2: begin rate = 18'd100; gain = 15'd1; end
        3: begin rate = '1; gain = 15'($urandom_range(1, 32767)); end
        4: begin rate = 18'd8000; gain = 15'($urandom_range(1, 32767)); end
        5: begin rate = 18'd192000; gain = '1; end
        6: begin
          rate = 18'($urandom_range(8000, 192000));
          gain = 15'($urandom_range(1, 32767));
        end
        default: begin rate = RATE_W'($urandom); gain = GAIN_W'($urandom); end
      endcase
      set_config(rate, gain);
      sender_gaps = ($urandom_range(0, 3) != 0);
      counted = 0;
      while (counted < PHASE_WORDS) begin
        ch = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(2, 15))
                                         : 4'($urandom_range(0, NUM_CH - 1));
        if (ch < NUM_CH) counted++;
        if ($urandom_range(0, 39) == 0) send_word(FUNC_FLUSH, ch, rand_sample());
        else send_word(FUNC_SAMPLE, ch, rand_sample());
      end
    end
    sender_gaps = 1'b1;
  endtask

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_frame();
    test_flush();
    test_ignored_channels();
    test_zero_rate_and_gain();
    test_short_window();
    test_random_settings();
    wait_idle();
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("audio_peak_envelope_builder_tb passed");
    end else begin
      $display("audio_peak_envelope_builder_tb failed");
    end
    $finish;
  end

endmodule
